@@ hw/rtl/bba_pkg.sv @@
// shared types and constants of the bitmap block allocator
package bba_pkg;

  localparam int NUM_BLOCKS_DEF  = 2048;
  localparam int BLOCK_BYTES_DEF = 512;

  // used-bit map word width and bit index width inside one word
  localparam int WORD_BITS = 128;
  localparam int BIT_W     = $clog2(WORD_BITS);

  // item field widths
  localparam int REQ_W       = 16;
  localparam int FOFF_W      = 21;
  localparam int OFF_W       = 20;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic    clear_en;
    logic    take_in;
    logic    scan_en;
    logic    alloc_wr;
    logic    free_rd;
    logic    free_wr;
    logic    res_set;
    status_t res_status;
    logic    out_load;
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic in_free;
    logic in_too_large;
    logic scan_live;
    logic scan_found;
    logic scan_last;
    logic free_in_range;
    logic out_free;
  } bba_stat_t;

endpackage

@@ hw/rtl/bba_datapath.sv @@
// used-bit map memory, first-free search, offset arithmetic and output register
module bba_datapath #(
  parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bba_pkg::bba_cmd_t                cmd,
  output bba_pkg::bba_stat_t               stat,
  input  logic [bba_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tuser,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [bba_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [1:0]                       m_tuser
);
  import bba_pkg::*;

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int GIDX_W    = WA + BIT_W;
  localparam int SHIFT     = FOFF_W + $clog2(BLOCK_BYTES);
  localparam int MAGIC_W   = FOFF_W + 1;
  localparam int PROD_W    = FOFF_W + MAGIC_W;
  localparam int Q_W       = PROD_W - SHIFT;
  localparam int BB_W      = $clog2(BLOCK_BYTES + 1);
  // reciprocal of the block size, exact for every 21-bit offset
  localparam longint MAGIC = ((longint'(1) << SHIFT) + longint'(BLOCK_BYTES) - 1)
                             / longint'(BLOCK_BYTES);
  localparam logic [MAGIC_W-1:0] MAGIC_V   = MAGIC[MAGIC_W-1:0];
  localparam logic [BB_W-1:0]    BB_V      = BB_W'(BLOCK_BYTES);
  localparam logic [WA-1:0]      LAST_WORD = WA'(NUM_WORDS - 1);
  localparam logic [GIDX_W:0]    NB_V      = (GIDX_W + 1)'(NUM_BLOCKS);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_we;
  logic                 mem_re;
  logic [WA-1:0]        mem_waddr;
  logic [WA-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [WA-1:0]        clr_addr;
  logic [WA-1:0]        scan_addr;
  logic [WA-1:0]        data_addr;
  logic [WA-1:0]        wr_addr;
  logic                 rd_live;
  logic [WORD_BITS-1:0] set_word;
  logic [GIDX_W-1:0]    alloc_idx;
  logic [BIT_W-1:0]     free_bit;

  logic [FOFF_W-1:0]    foff;
  logic [PROD_W-1:0]    prod;
  logic [Q_W-1:0]       quot;
  logic [31:0]          quot32;

  logic [WORD_BITS-1:0] zero_vec;
  logic                 has_zero;
  logic [BIT_W-1:0]     first_bit;
  logic [GIDX_W-1:0]    gidx;
  logic [GIDX_W+BB_W-1:0] off_prod;

  status_t              res_status;
  logic [OFF_W-1:0]     res_offset;
  status_t              out_status;
  logic [OFF_W-1:0]     out_offset;
  logic                 out_valid;

  // lowest clear bit of the word just read
  always_comb begin
    zero_vec  = ~rd_data;
    has_zero  = |zero_vec;
    first_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (zero_vec[i]) begin
        first_bit = BIT_W'(i);
      end
    end
  end

  assign gidx     = {data_addr, first_bit};
  assign quot     = prod[PROD_W-1:SHIFT];
  assign quot32   = 32'(quot);
  assign off_prod = alloc_idx * BB_V;

  always_comb begin
    mem_we    = cmd.clear_en | cmd.alloc_wr | cmd.free_wr;
    mem_waddr = wr_addr;
    mem_wdata = set_word;
    if (cmd.clear_en) begin
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (cmd.free_wr) begin
      mem_wdata = rd_data & ~(WORD_BITS'(1) << free_bit);
    end
    mem_re    = cmd.scan_en | cmd.free_rd;
    mem_raddr = cmd.free_rd ? quot32[BIT_W +: WA] : scan_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // clearing pass and scan pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      scan_addr <= '0;
      data_addr <= '0;
      rd_live   <= 1'b0;
    end else begin
      if (cmd.clear_en && clr_addr != LAST_WORD) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.take_in) begin
        scan_addr <= '0;
        rd_live   <= 1'b0;
      end else if (cmd.scan_en) begin
        data_addr <= scan_addr;
        rd_live   <= 1'b1;
        if (scan_addr != LAST_WORD) begin
          scan_addr <= scan_addr + 1'b1;
        end
      end
    end
  end

  // write-back staging and offset arithmetic
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      foff <= s_tdata[REQ_W +: FOFF_W];
    end
    prod <= foff * MAGIC_V;
    if (cmd.scan_en && rd_live) begin
      wr_addr   <= data_addr;
      set_word  <= rd_data | (WORD_BITS'(1) << first_bit);
      alloc_idx <= gidx;
    end else if (cmd.free_rd) begin
      wr_addr  <= quot32[BIT_W +: WA];
      free_bit <= quot32[BIT_W-1:0];
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_offset <= '0;
    end else if (cmd.alloc_wr) begin
      res_status <= ST_OK;
      res_offset <= OFF_W'(off_prod);
    end else if (cmd.free_wr) begin
      res_status <= ST_OK;
      res_offset <= '0;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_offset <= res_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_offset);
  assign m_tuser  = out_status;

  always_comb begin
    stat.clear_last    = clr_addr == LAST_WORD;
    stat.in_free       = opcode_t'(s_tuser) == OP_FREE;
    stat.in_too_large  = 32'(s_tdata[REQ_W-1:0]) > 32'(BLOCK_BYTES);
    stat.scan_live     = rd_live;
    stat.scan_found    = has_zero && ({1'b0, gidx} < NB_V);
    stat.scan_last     = data_addr == LAST_WORD;
    stat.free_in_range = quot32 < 32'(NUM_BLOCKS);
    stat.out_free      = !out_valid || m_tready;
  end

endmodule

@@ hw/rtl/bba_ctrl.sv @@
// allocator control state machine
module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               in_ready,
  input  bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t  cmd
);
  import bba_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_ALLOC_WR = 8'b0000_1000,
    S_FREE_MUL = 8'b0001_0000,
    S_FREE_CHK = 8'b0010_0000,
    S_FREE_WR  = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = ST_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take_in = 1'b1;
          if (stat.in_free) begin
            state_next = S_FREE_MUL;
          end else if (stat.in_too_large) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_TOO_LARGE;
            state_next     = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_live && stat.scan_found) begin
          state_next = S_ALLOC_WR;
        end else if (stat.scan_live && stat.scan_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FULL;
          state_next     = S_DONE;
        end
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_FREE_MUL: begin
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (stat.free_in_range) begin
          cmd.free_rd = 1'b1;
          state_next  = S_FREE_WR;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_BAD_FREE;
          state_next     = S_DONE;
        end
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // a block is only marked used after the scan saw a clear bit
  a_alloc_after_found: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_wr |-> $past(stat.scan_live && stat.scan_found))
    else $error("allocation write without a found clear bit");

  // a free write only follows an in-range index
  a_free_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.free_wr |-> $past(stat.free_in_range))
    else $error("free write for an index outside the region");

  // the scan keeps going until a hit or the last word
  a_scan_continues: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.scan_live && !stat.scan_found && !stat.scan_last)
    |=> (state == S_SCAN))
    else $error("scan stopped early");

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.take_in |=> !in_ready)
    else $error("new item taken while one is still in work");

endmodule

@@ hw/rtl/bitmap_block_allocator.sv @@
// top level of the first-fit bitmap block allocator
//
// usage
//   input channel s_*: one item per request. s_tuser is the opcode (allocate or free),
//   s_tdata carries the byte count of an allocate and the byte offset of a free.
//   output channel m_*: exactly one item per request. m_tuser is the status
//   (ok, too large, region full, bad free offset), m_tdata the block offset.
// timing
//   one item at a time; the map is held as words of 128 used bits in one memory
//   with a single read and a single write port, scanned one word a cycle.
//   an allocate scans the words in order up to the one that holds the first free
//   block and writes that word back; a full region scans every word. A free
//   divides its offset by the block size, checks the range, then reads and writes
//   the word; a bad free stops after the check, a too-large allocate at once.
// reset
//   the map memory is swept to all free, one word a cycle, over all of its words;
//   s_tready stays low until the sweep is done.
// stall
//   a finished result sits in the output register; the next item is taken while it
//   waits, and its own result is held back until the register empties.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // request_bytes [15:0], free_offset [36:16], zero pad [39:37]
  input  logic [bba_pkg::IN_TDATA_W-1:0]  s_tdata,
  // opcode [0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // block_offset [19:0], zero pad [23:20]
  output logic [bba_pkg::OUT_TDATA_W-1:0] m_tdata,
  // status [1:0]
  output logic [1:0]                      m_tuser
);
  import bba_pkg::*;

  bba_cmd_t  cmd;   // controller commands
  bba_stat_t stat;  // datapath status flags

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // map memory, search, divide-by-block-size and output register
  bba_datapath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
